// File: sv/markov_transition_count_table_macros.svh
// Assertion helpers shared by the table's RTL.
`ifndef MARKOV_TRANSITION_COUNT_TABLE_MACROS_SVH
`define MARKOV_TRANSITION_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MTCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mtct_pkg.sv
package mtct_pkg;

  localparam int NUM_STATES = 64;
  localparam int STATE_W    = $clog2(NUM_STATES);
  localparam int COUNT_W    = 16;
  localparam int PROB_W     = 17;
  localparam int PAIR_DEPTH = NUM_STATES * NUM_STATES;
  localparam int PAIR_AW    = 2 * STATE_W;
  localparam int STEP_W     = STATE_W + 1;
  localparam int ALU_W      = COUNT_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_Q_PAIR,
    ST_Q_SCAN,
    ST_Q_DIV,
    ST_Q_DONE
  } state_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

// File: sv/mtct_in_if.sv
interface mtct_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [mtct_pkg::STATE_W-1:0]  from_state;
  logic [mtct_pkg::STATE_W-1:0]  dest_state;

  modport source (output valid, operation, from_state, dest_state, input ready);
  modport sink   (input valid, operation, from_state, dest_state, output ready);
endinterface

// File: sv/mtct_out_if.sv
interface mtct_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtct_pkg::STATE_W-1:0]  best_next;
  logic                          best_found;
  logic [mtct_pkg::COUNT_W-1:0]  row_total;
  logic [mtct_pkg::COUNT_W-1:0]  pair_count;
  logic [mtct_pkg::PROB_W-1:0]   probability;

  modport source (output valid, best_next, best_found, row_total, pair_count, probability,
                  input ready);
  modport sink   (input valid, best_next, best_found, row_total, pair_count, probability,
                  output ready);
endinterface

// File: sv/markov_transition_count_table.sv
// Transition count table for a first-order Markov chain over 64 states.
// The req channel carries one word per observation or query: operation
// 0 adds one transition from_state -> dest_state, operation 1 queries it.
// An add gives no result: the block reads the pair count and the row total,
// then writes both back with a saturating increment.
// A query gives one word on the rsp channel: row total, pair count,
// probability in Q1.16, the most frequent next state and a found flag.
// A query captures the pair and the row total, walks the row (one memory
// read per cycle), runs a restoring division on the same shared 18-bit
// subtractor as the walk, and loads the output register. No new word is
// accepted until the query is done and the block is back in idle.
// The result sits in an output register; the next word is accepted while
// it waits, but a following query holds in its last state until the
// receiver takes the earlier result.
// After reset the block sweeps all 4096 table entries to zero, one entry a
// cycle, with req.ready low throughout.
module markov_transition_count_table (
  input logic clk,
  input logic rst,
  mtct_in_if.sink     req,
  mtct_out_if.source  rsp
);

  `include "markov_transition_count_table_macros.svh"

  mtct_pkg::state_t state, state_next;

  logic [mtct_pkg::COUNT_W-1:0] pair_mem [mtct_pkg::PAIR_DEPTH];
  logic [mtct_pkg::COUNT_W-1:0] row_mem  [mtct_pkg::NUM_STATES];

  logic [mtct_pkg::PAIR_AW-1:0] pair_raddr, pair_waddr;
  logic [mtct_pkg::STATE_W-1:0] row_raddr, row_waddr;
  logic [mtct_pkg::COUNT_W-1:0] pair_wdata, row_wdata, pair_q, row_q;
  logic                         pair_we, row_we;

  logic [mtct_pkg::PAIR_AW-1:0] clr_addr;
  logic [mtct_pkg::STEP_W-1:0]  step;
  logic [mtct_pkg::STATE_W-1:0] src, dst;
  logic [mtct_pkg::COUNT_W-1:0] pair_val, total_val, best_cnt;
  logic [mtct_pkg::STATE_W-1:0] best_idx;
  logic                         found;
  logic [mtct_pkg::COUNT_W:0]   rem;
  logic [mtct_pkg::PROB_W-1:0]  quo;

  logic                         out_valid;
  logic [mtct_pkg::STATE_W-1:0] out_best_next;
  logic                         out_best_found;
  logic [mtct_pkg::COUNT_W-1:0] out_row_total, out_pair_count;
  logic [mtct_pkg::PROB_W-1:0]  out_probability;
  logic                         out_load;

  logic [mtct_pkg::ALU_W-1:0]   alu_a, alu_b, alu_diff;
  logic                         alu_borrow;
  logic                         accept;

  assign accept = req.valid && req.ready;

  // The shared subtractor: a row compare during the walk, a trial
  // subtraction during the division.
  always_comb begin
    case (state)
      mtct_pkg::ST_Q_DIV: begin
        alu_a = {1'b0, rem};
        alu_b = {2'b00, total_val};
      end
      default: begin
        alu_a = {2'b00, best_cnt};
        alu_b = {2'b00, pair_q};
      end
    endcase
  end
  assign alu_diff   = alu_a - alu_b;
  assign alu_borrow = alu_diff[mtct_pkg::ALU_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtct_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    out_load   = 1'b0;
    pair_we    = 1'b0;
    row_we     = 1'b0;
    pair_waddr = {src, dst};
    row_waddr  = src;
    pair_wdata = (pair_q == '1) ? pair_q : pair_q + 1'b1;
    row_wdata  = (row_q == '1) ? row_q : row_q + 1'b1;
    pair_raddr = {src, dst};
    row_raddr  = src;
    case (state)
      mtct_pkg::ST_CLEAR: begin
        pair_we    = 1'b1;
        row_we     = 1'b1;
        pair_waddr = clr_addr;
        row_waddr  = clr_addr[mtct_pkg::STATE_W-1:0];
        pair_wdata = '0;
        row_wdata  = '0;
        if (clr_addr == '1) begin
          state_next = mtct_pkg::ST_IDLE;
        end
      end
      mtct_pkg::ST_IDLE: begin
        req.ready  = 1'b1;
        pair_raddr = {req.from_state, req.dest_state};
        row_raddr  = req.from_state;
        if (req.valid) begin
          state_next = (req.operation == mtct_pkg::OP_ADD) ? mtct_pkg::ST_ADD_WR
                                                           : mtct_pkg::ST_Q_PAIR;
        end
      end
      mtct_pkg::ST_ADD_WR: begin
        pair_we    = 1'b1;
        row_we     = 1'b1;
        state_next = mtct_pkg::ST_IDLE;
      end
      mtct_pkg::ST_Q_PAIR: begin
        state_next = mtct_pkg::ST_Q_SCAN;
      end
      mtct_pkg::ST_Q_SCAN: begin
        pair_raddr = {src, step[mtct_pkg::STATE_W-1:0]};
        if (step == mtct_pkg::STEP_W'(mtct_pkg::NUM_STATES)) begin
          state_next = mtct_pkg::ST_Q_DIV;
        end
      end
      mtct_pkg::ST_Q_DIV: begin
        if (step == mtct_pkg::STEP_W'(mtct_pkg::PROB_W - 1)) begin
          state_next = mtct_pkg::ST_Q_DONE;
        end
      end
      mtct_pkg::ST_Q_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = mtct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    pair_q <= pair_mem[pair_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      step     <= '0;
    end else begin
      if (state == mtct_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      case (state)
        mtct_pkg::ST_Q_SCAN: begin
          step <= (step == mtct_pkg::STEP_W'(mtct_pkg::NUM_STATES)) ? '0 : step + 1'b1;
        end
        mtct_pkg::ST_Q_DIV: begin
          step <= step + 1'b1;
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src <= req.from_state;
      dst <= req.dest_state;
    end
    case (state)
      mtct_pkg::ST_Q_PAIR: begin
        pair_val  <= pair_q;
        total_val <= row_q;
        rem       <= {1'b0, pair_q};
        quo       <= '0;
        best_cnt  <= '0;
        best_idx  <= '0;
        found     <= 1'b0;
      end
      mtct_pkg::ST_Q_SCAN: begin
        // Read data is registered behind the address, so entry step-1 is judged here.
        // A strict greater-than keeps the lowest index on a tie.
        if (step != '0 && alu_borrow) begin
          best_cnt <= pair_q;
          best_idx <= mtct_pkg::STATE_W'(step - 1'b1);
          found    <= 1'b1;
        end
      end
      mtct_pkg::ST_Q_DIV: begin
        // The remainder stays below the divisor, so it fits the counter width.
        rem <= alu_borrow ? {rem[mtct_pkg::COUNT_W-1:0], 1'b0}
                          : {alu_diff[mtct_pkg::COUNT_W-1:0], 1'b0};
        quo <= {quo[mtct_pkg::PROB_W-2:0], !alu_borrow};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_next   <= best_idx;
      out_best_found  <= found;
      out_row_total   <= total_val;
      out_pair_count  <= pair_val;
      out_probability <= (total_val == '0) ? '0 : quo;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.best_next   = out_best_next;
  assign rsp.best_found  = out_best_found;
  assign rsp.row_total   = out_row_total;
  assign rsp.pair_count  = out_pair_count;
  assign rsp.probability = out_probability;

  `MTCT_ASSERT_NEXT(a_add_writes, clk, rst, accept && req.operation == mtct_pkg::OP_ADD, pair_we && row_we, "add word was not written back")
  `MTCT_ASSERT_NOW(a_no_write_in_query, clk, rst, state == mtct_pkg::ST_Q_SCAN || state == mtct_pkg::ST_Q_DIV, !pair_we && !row_we, "table written during a query")
  `MTCT_ASSERT_NOW(a_empty_row_index, clk, rst, rsp.valid && !rsp.best_found, rsp.best_next == '0, "empty row reports a nonzero best state")
  `MTCT_ASSERT_NOW(a_prob_bound, clk, rst, rsp.valid, rsp.probability <= mtct_pkg::PROB_W'(1 << mtct_pkg::COUNT_W), "probability above one")

endmodule

// File: tb/markov_transition_count_table_test.sv
module markov_transition_count_table_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_WORDS = 1200;

  typedef struct packed {
    logic [mtct_pkg::STATE_W-1:0] best_next;
    logic                         best_found;
    logic [mtct_pkg::COUNT_W-1:0] row_total;
    logic [mtct_pkg::COUNT_W-1:0] pair_count;
    logic [mtct_pkg::PROB_W-1:0]  probability;
  } query_result_t;

  // Shadow copy of the count table and the queue of query results still owed.
  class count_table_scoreboard;
    logic [mtct_pkg::COUNT_W-1:0] pair_tab [mtct_pkg::PAIR_DEPTH];
    logic [mtct_pkg::COUNT_W-1:0] row_tab [mtct_pkg::NUM_STATES];
    query_result_t                owed_results [$];
    int                           mismatches;

    function new();
      foreach (pair_tab[i]) pair_tab[i] = '0;
      foreach (row_tab[i]) row_tab[i] = '0;
      mismatches = 0;
    endfunction

    function logic [mtct_pkg::COUNT_W-1:0] bump(logic [mtct_pkg::COUNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function query_result_t predict_query(logic [mtct_pkg::STATE_W-1:0] f,
                                          logic [mtct_pkg::STATE_W-1:0] d);
      query_result_t                  r;
      logic [mtct_pkg::COUNT_W-1:0]   top_count;
      logic [mtct_pkg::COUNT_W-1:0]   c;
      logic [2*mtct_pkg::COUNT_W-1:0] scaled;
      int                             i;
      r = '0;
      top_count = '0;
      r.row_total  = row_tab[f];
      r.pair_count = pair_tab[{f, d}];
      // Strictly greater, so the lowest index keeps a tie.
      for (i = 0; i < mtct_pkg::NUM_STATES; i++) begin
        c = pair_tab[{f, mtct_pkg::STATE_W'(i)}];
        if (c > top_count) begin
          top_count    = c;
          r.best_next  = mtct_pkg::STATE_W'(i);
          r.best_found = 1'b1;
        end
      end
      if (r.row_total != '0) begin
        scaled = {r.pair_count, 16'h0000} / {16'h0000, r.row_total};
        r.probability = scaled[mtct_pkg::PROB_W-1:0];
      end
      return r;
    endfunction

    function void note_word(mtct_pkg::op_t op, logic [mtct_pkg::STATE_W-1:0] f,
                            logic [mtct_pkg::STATE_W-1:0] d);
      if (op == mtct_pkg::OP_ADD) begin
        pair_tab[{f, d}] = bump(pair_tab[{f, d}]);
        row_tab[f]       = bump(row_tab[f]);
      end else begin
        owed_results.push_back(predict_query(f, d));
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(query_result_t got);
      query_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("result word with nothing owed (row_total)", got.row_total, 0);
        return;
      end
      want = owed_results.pop_front();
      if (got.best_next !== want.best_next)
        report_mismatch("best_next", got.best_next, want.best_next);
      if (got.best_found !== want.best_found)
        report_mismatch("best_found", got.best_found, want.best_found);
      if (got.row_total !== want.row_total)
        report_mismatch("row_total", got.row_total, want.row_total);
      if (got.pair_count !== want.pair_count)
        report_mismatch("pair_count", got.pair_count, want.pair_count);
      if (got.probability !== want.probability)
        report_mismatch("probability", got.probability, want.probability);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_toggle = 1'b0;
  int   cycle_count = 0;

  count_table_scoreboard sb;

  mtct_in_if  req_if ();
  mtct_out_if rsp_if ();

  markov_transition_count_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: takes result words, stalling on a pattern that changes now and then,
  // and holds off for a long stretch whenever the sender flips hold_toggle.
  initial begin : receiver
    int            mode;
    int            mode_left;
    int            hold_left;
    logic          seen_toggle;
    logic          take;
    query_result_t got;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    seen_toggle = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        got.best_next   = rsp_if.best_next;
        got.best_found  = rsp_if.best_found;
        got.row_total   = rsp_if.row_total;
        got.pair_count  = rsp_if.pair_count;
        got.probability = rsp_if.probability;
        sb.check_result(got);
      end
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (mode)
          0: take = 1'b1;
          1: take = $urandom_range(0, 1);
          2: take = ($urandom_range(0, 9) != 0);
          default: take = ((mode_left % 5) >= 2);
        endcase
      end
      rsp_if.ready <= take;
    end
  end

  // Offers one word and returns at the edge where it is taken.
  task send_word(input mtct_pkg::op_t op, input logic [mtct_pkg::STATE_W-1:0] f,
                 input logic [mtct_pkg::STATE_W-1:0] d);
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.from_state <= f;
    req_if.dest_state <= d;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_word(op, f, d);
  endtask

  task idle_gap(input int cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task send_random_word();
    mtct_pkg::op_t                op;
    logic [mtct_pkg::STATE_W-1:0] f;
    logic [mtct_pkg::STATE_W-1:0] d;
    op = ($urandom_range(0, 99) < 60) ? mtct_pkg::OP_ADD : mtct_pkg::OP_QUERY;
    // Mostly a few busy rows and columns so that counts build up and ties occur.
    if ($urandom_range(0, 9) < 7) f = mtct_pkg::STATE_W'($urandom_range(8, 15));
    else f = mtct_pkg::STATE_W'($urandom_range(0, mtct_pkg::NUM_STATES - 1));
    if ($urandom_range(0, 9) < 7) begin
      d = mtct_pkg::STATE_W'($urandom_range(0, 7));
      if (d >= 6'd4) d = d + 6'd56;
    end else begin
      d = mtct_pkg::STATE_W'($urandom_range(0, mtct_pkg::NUM_STATES - 1));
    end
    send_word(op, f, d);
  endtask

  initial begin : sender
    int burst_left;
    int n;
    sb = new();
    req_if.valid      = 1'b0;
    req_if.operation  = mtct_pkg::OP_ADD;
    req_if.from_state = '0;
    req_if.dest_state = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty rows, index extremes, a tie, truncation and a full share.
    send_word(mtct_pkg::OP_QUERY, 6'd0, 6'd0);
    send_word(mtct_pkg::OP_QUERY, 6'd63, 6'd63);
    send_word(mtct_pkg::OP_ADD, 6'd1, 6'd10);
    send_word(mtct_pkg::OP_ADD, 6'd1, 6'd3);
    send_word(mtct_pkg::OP_QUERY, 6'd1, 6'd10);
    send_word(mtct_pkg::OP_ADD, 6'd1, 6'd10);
    send_word(mtct_pkg::OP_QUERY, 6'd1, 6'd3);
    send_word(mtct_pkg::OP_ADD, 6'd0, 6'd63);
    send_word(mtct_pkg::OP_ADD, 6'd63, 6'd0);
    send_word(mtct_pkg::OP_QUERY, 6'd0, 6'd63);
    send_word(mtct_pkg::OP_QUERY, 6'd63, 6'd0);
    send_word(mtct_pkg::OP_QUERY, 6'd0, 6'd0);
    send_word(mtct_pkg::OP_ADD, 6'd42, 6'd21);
    send_word(mtct_pkg::OP_ADD, 6'd21, 6'd42);
    send_word(mtct_pkg::OP_QUERY, 6'd42, 6'd42);
    send_word(mtct_pkg::OP_QUERY, 6'd21, 6'd42);
    repeat (3) send_word(mtct_pkg::OP_ADD, 6'd2, 6'd5);
    send_word(mtct_pkg::OP_QUERY, 6'd2, 6'd5);
    send_word(mtct_pkg::OP_ADD, 6'd3, 6'd1);
    send_word(mtct_pkg::OP_ADD, 6'd3, 6'd2);
    send_word(mtct_pkg::OP_ADD, 6'd3, 6'd2);
    send_word(mtct_pkg::OP_QUERY, 6'd3, 6'd1);
    send_word(mtct_pkg::OP_QUERY, 6'd3, 6'd2);
    wait_drained();

    burst_left = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        // Back-pressure: the receiver stops while queries keep arriving.
        hold_toggle <= ~hold_toggle;
        repeat (6) send_word(mtct_pkg::OP_QUERY,
                             mtct_pkg::STATE_W'($urandom_range(0, mtct_pkg::NUM_STATES - 1)),
                             mtct_pkg::STATE_W'($urandom_range(0, mtct_pkg::NUM_STATES - 1)));
      end
      if (n == 2 * RANDOM_WORDS / 3) wait_drained();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      send_random_word();
    end

    wait_drained();
    repeat (120) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/mtct_pkg.sv
sv/mtct_in_if.sv
sv/mtct_out_if.sv
sv/markov_transition_count_table.sv
tb/markov_transition_count_table_test.sv
